// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the segment intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on i_clk, off during reset.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/core/sis_pkg.sv -----
// Package: widths, relation codes and the job type of the segment intersection unit.
`timescale 1ns / 1ps
package sis_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;       // coordinate difference
    localparam int PW = 2 * DW;       // one cross-product term
    localparam int SW = PW + 1;       // difference of two terms
    localparam int MW = PW;           // magnitude of a SW value
    localparam int QW = DW;           // quotient bits
    localparam int NW = DW + MW;      // dividend
    localparam int QDEPTH = 4;        // power of two, pointers wrap
    localparam int QPW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    localparam logic [2:0] REL_PARALLEL   = 3'd0;
    localparam logic [2:0] REL_COLLINEAR  = 3'd1;
    localparam logic [2:0] REL_MISS_SECOND = 3'd2;
    localparam logic [2:0] REL_CROSS      = 3'd3;
    localparam logic [2:0] REL_MISS_FIRST = 3'd4;

    typedef struct packed {
        logic [2:0]          rel;
        logic [CW-1:0]       ax;
        logic [CW-1:0]       ay;
        logic                negx;
        logic                negy;
    } t_tag;

    typedef struct packed {
        t_tag                tag;
        logic [DW-1:0]       mdx;
        logic [DW-1:0]       mdy;
        logic [MW-1:0]       tmag;
        logic [MW-1:0]       dmag;
    } t_job;
endpackage

// ----- rtl/core/sis_if.sv -----
// Channel interfaces: segment pair in, classification result out.
`timescale 1ns / 1ps
interface sis_pair_if;
    import sis_pkg::*;
    logic valid;
    logic ready;
    logic signed [CW-1:0] first_start_x;
    logic signed [CW-1:0] first_start_y;
    logic signed [CW-1:0] first_end_x;
    logic signed [CW-1:0] first_end_y;
    logic signed [CW-1:0] second_start_x;
    logic signed [CW-1:0] second_start_y;
    logic signed [CW-1:0] second_end_x;
    logic signed [CW-1:0] second_end_y;
    modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                    second_start_x, second_start_y, second_end_x, second_end_y,
                    input ready);
    modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  output ready);
endinterface

interface sis_res_if;
    import sis_pkg::*;
    logic valid;
    logic ready;
    logic [2:0] relation;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
    modport source (output valid, relation, cross_x, cross_y, input ready);
    modport sink (input valid, relation, cross_x, cross_y, output ready);
endinterface

// ----- rtl/core/sis_front.sv -----
// Front end: differences, cross products and classification of each pair.
`timescale 1ns / 1ps
module sis_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sis_pair_if.sink       i_pair,
    output logic           o_job_valid,
    output sis_pkg::t_job  o_job,
    input  logic           i_job_ready
);
    import sis_pkg::*;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4;
    logic signed [DW-1:0] r_dfx, r_dfy, r_dsx, r_dsy, r_acx, r_acy;
    logic signed [DW-1:0] r2_dfx, r2_dfy, r3_dfx, r3_dfy;
    logic [CW-1:0] r_ax, r_ay, r2_ax, r2_ay, r3_ax, r3_ay;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [SW-1:0] r_den, r_sp, r_tp;
    logic signed [SW-1:0] nden, den_abs, tp_abs;
    logic den_zero, den_neg, in_s, in_t;
    logic [2:0] rel;
    t_job n_job, r_job;

    assign en = !r_v4 || i_job_ready;
    assign i_pair.ready = en;
    assign o_job_valid = r_v4;
    assign o_job = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_pair.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 1: differences
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dfx <= {i_pair.first_end_x[CW-1], i_pair.first_end_x}
                   - {i_pair.first_start_x[CW-1], i_pair.first_start_x};
            r_dfy <= {i_pair.first_end_y[CW-1], i_pair.first_end_y}
                   - {i_pair.first_start_y[CW-1], i_pair.first_start_y};
            r_dsx <= {i_pair.second_end_x[CW-1], i_pair.second_end_x}
                   - {i_pair.second_start_x[CW-1], i_pair.second_start_x};
            r_dsy <= {i_pair.second_end_y[CW-1], i_pair.second_end_y}
                   - {i_pair.second_start_y[CW-1], i_pair.second_start_y};
            r_acx <= {i_pair.second_start_x[CW-1], i_pair.second_start_x}
                   - {i_pair.first_start_x[CW-1], i_pair.first_start_x};
            r_acy <= {i_pair.second_start_y[CW-1], i_pair.second_start_y}
                   - {i_pair.first_start_y[CW-1], i_pair.first_start_y};
            r_ax  <= i_pair.first_start_x;
            r_ay  <= i_pair.first_start_y;
        end
    end

    // stage 2: six products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0 <= r_dfy * r_dsx;
            r_p1 <= r_dfx * r_dsy;
            r_p2 <= r_dfx * r_acy;
            r_p3 <= r_acx * r_dfy;
            r_p4 <= r_dsy * r_acx;
            r_p5 <= r_dsx * r_acy;
            r2_dfx <= r_dfx;
            r2_dfy <= r_dfy;
            r2_ax <= r_ax;
            r2_ay <= r_ay;
        end
    end

    // stage 3: den, s and t numerators (s numerator doubles as the side test)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= {r_p0[PW-1], r_p0} - {r_p1[PW-1], r_p1};
            r_sp  <= {r_p2[PW-1], r_p2} - {r_p3[PW-1], r_p3};
            r_tp  <= {r_p4[PW-1], r_p4} - {r_p5[PW-1], r_p5};
            r3_dfx <= r2_dfx;
            r3_dfy <= r2_dfy;
            r3_ax <= r2_ax;
            r3_ay <= r2_ay;
        end
    end

    // stage 4: classify
    always_comb begin
        den_zero = (r_den == '0);
        den_neg  = r_den[SW-1];
        nden     = -r_den;
        den_abs  = den_neg ? nden : r_den;
        tp_abs   = r_tp[SW-1] ? -r_tp : r_tp;
        if (den_neg)
            in_s = (r_sp >= r_den) && (r_sp[SW-1] || r_sp == '0);
        else
            in_s = !r_sp[SW-1] && (r_sp <= r_den);
        if (!den_neg)
            in_t = (r_tp >= nden) && (r_tp[SW-1] || r_tp == '0);
        else
            in_t = !r_tp[SW-1] && (r_tp <= nden);
        if (den_zero)
            rel = (r_sp == '0) ? REL_COLLINEAR : REL_PARALLEL;
        else if (!in_s)
            rel = REL_MISS_SECOND;
        else if (in_t)
            rel = REL_CROSS;
        else
            rel = REL_MISS_FIRST;
        n_job.tag.rel  = rel;
        n_job.tag.ax   = r3_ax;
        n_job.tag.ay   = r3_ay;
        n_job.tag.negx = r3_dfx[DW-1] ^ r_tp[SW-1] ^ !den_neg;
        n_job.tag.negy = r3_dfy[DW-1] ^ r_tp[SW-1] ^ !den_neg;
        n_job.mdx  = r3_dfx[DW-1] ? DW'(-r3_dfx) : DW'(r3_dfx);
        n_job.mdy  = r3_dfy[DW-1] ? DW'(-r3_dfy) : DW'(r3_dfy);
        n_job.tmag = tp_abs[MW-1:0];
        n_job.dmag = den_abs[MW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) r_job <= n_job;
    end
endmodule

// ----- rtl/core/sis_fifo.sv -----
// Job queue between front and back ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sis_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  sis_pkg::t_job  i_job,
    output logic           o_ready,
    output logic           o_valid,
    output sis_pkg::t_job  o_job,
    input  logic           i_ready
);
    import sis_pkg::*;

    t_job r_mem [QDEPTH];
    logic [QPW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QCW'(push) - QCW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_job;
    end

    `AST_SAME(a_cnt_bound, 1'b1, r_cnt <= QCW'(QDEPTH))
    `AST_NEXT(a_push_only, push && !pop, r_cnt == $past(r_cnt) + 1'b1)
    `AST_NEXT(a_pop_only, pop && !push, r_cnt == $past(r_cnt) - 1'b1)
endmodule

// ----- rtl/core/sis_back.sv -----
// Back end: point products, pipelined restoring divide, output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sis_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  sis_pkg::t_job  i_job,
    output logic           o_job_ready,
    sis_res_if.source      o_res
);
    import sis_pkg::*;

    typedef struct packed {
        logic [MW-1:0] rem;
        logic [QW-1:0] sh;
    } t_dstep;

    function automatic t_dstep div_step(input logic [MW-1:0] rem, input logic [QW-1:0] sh,
                                        input logic [MW-1:0] d);
        logic [MW:0] t;
        logic ge;
        t_dstep r;
        t = {rem, sh[QW-1]};
        ge = (t >= {1'b0, d});
        r.rem = ge ? MW'(t - {1'b0, d}) : t[MW-1:0];
        r.sh = {sh[QW-2:0], ge};
        return r;
    endfunction

    logic en;
    logic r_v1, r_vo;
    logic r_v [0:QW];
    t_tag r1_tag;
    logic [MW-1:0] r1_dm;
    logic [PW-1:0] r_plx, r_phx, r_ply, r_phy;
    logic [NW-1:0] numx, numy;
    t_tag r_tag [0:QW];
    logic [MW-1:0] r_dm [0:QW];
    logic [MW-1:0] r_rx [0:QW];
    logic [MW-1:0] r_ry [0:QW];
    logic [QW-1:0] r_sx [0:QW];
    logic [QW-1:0] r_sy [0:QW];
    t_dstep n_dx [1:QW];
    t_dstep n_dy [1:QW];
    logic [2:0] r_rel;
    logic [CW-1:0] r_px, r_py;
    logic [DW:0] sqx, sqy;
    t_tag ft;

    assign en = !r_vo || o_res.ready;
    assign o_job_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_vo <= 1'b0;
            for (int k = 0; k <= QW; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v1 <= i_job_valid;
            r_v[0] <= r_v1;
            for (int k = 1; k <= QW; k++) r_v[k] <= r_v[k-1];
            r_vo <= r_v[QW];
        end
    end

    // split products: |d| times the low and high halves of |t|
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_plx <= i_job.mdx * i_job.tmag[DW-1:0];
            r_phx <= i_job.mdx * i_job.tmag[MW-1:DW];
            r_ply <= i_job.mdy * i_job.tmag[DW-1:0];
            r_phy <= i_job.mdy * i_job.tmag[MW-1:DW];
            r1_tag <= i_job.tag;
            r1_dm <= i_job.dmag;
        end
    end

    assign numx = NW'(r_plx) + {r_phx, {DW{1'b0}}};
    assign numy = NW'(r_ply) + {r_phy, {DW{1'b0}}};

    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            n_dx[k] = div_step(r_rx[k-1], r_sx[k-1], r_dm[k-1]);
            n_dy[k] = div_step(r_ry[k-1], r_sy[k-1], r_dm[k-1]);
        end
    end

    // quotient fits QW bits, so the top MW dividend bits start below the divisor
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx[0]  <= numx[NW-1:QW];
            r_sx[0]  <= numx[QW-1:0];
            r_ry[0]  <= numy[NW-1:QW];
            r_sy[0]  <= numy[QW-1:0];
            r_tag[0] <= r1_tag;
            r_dm[0]  <= r1_dm;
            for (int k = 1; k <= QW; k++) begin
                r_rx[k]  <= n_dx[k].rem;
                r_sx[k]  <= n_dx[k].sh;
                r_ry[k]  <= n_dy[k].rem;
                r_sy[k]  <= n_dy[k].sh;
                r_tag[k] <= r_tag[k-1];
                r_dm[k]  <= r_dm[k-1];
            end
        end
    end

    always_comb begin
        ft  = r_tag[QW];
        sqx = ft.negx ? -{1'b0, r_sx[QW]} : {1'b0, r_sx[QW]};
        sqy = ft.negy ? -{1'b0, r_sy[QW]} : {1'b0, r_sy[QW]};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rel <= ft.rel;
            if (ft.rel == REL_CROSS) begin
                r_px <= CW'({{2{ft.ax[CW-1]}}, ft.ax} + sqx);
                r_py <= CW'({{2{ft.ay[CW-1]}}, ft.ay} + sqy);
            end else begin
                r_px <= '0;
                r_py <= '0;
            end
        end
    end

    assign o_res.valid    = r_vo;
    assign o_res.relation = r_rel;
    assign o_res.cross_x  = r_px;
    assign o_res.cross_y  = r_py;

    `AST_SAME(a_rel_code, r_vo, r_rel <= REL_MISS_FIRST)
    `AST_SAME(a_miss_zero, r_vo && r_rel != REL_CROSS, r_px == '0 && r_py == '0)
    `AST_NEXT(a_hold, r_vo && !o_res.ready, r_vo && $stable(r_rel) && $stable(r_px))
endmodule

// ----- rtl/core/segment_intersection_2d_unit.sv -----
// Top level of the 2D segment intersection unit: front end, job queue, back end.
// Path from input beat to result beat: front end, job queue, product and sum registers,
//   restoring divide, output register. The quotient is one restoring stage per bit.
// Throughput: one segment pair per cycle while the result sink does not stall.
// Reset: synchronous active-low i_rst_n clears all valid bits and the queue;
//   the datapath registers are not reset.
`timescale 1ns / 1ps
module segment_intersection_2d_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sis_pair_if.sink  i_pair,
    sis_res_if.source o_res
);
    import sis_pkg::*;

    // front -> queue
    logic f_valid, f_ready;
    t_job f_job;
    // queue -> back
    logic q_valid, q_ready;
    t_job q_job;

    // Front end: 4-stage pipeline computing differences, the six cross-product
    // terms, den/s/t numerators, and the relation code. Stalls only when the
    // queue is full.
    sis_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pair      (i_pair),
        .o_job_valid (f_valid),
        .o_job       (f_job),
        .i_job_ready (f_ready)
    );

    // Short job queue decouples the front from output back-pressure.
    sis_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_job   (f_job),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_ready (q_ready)
    );

    // Back end: |d|*|t| split into two partial products, then a fully pipelined
    // restoring divide by |den| for x and y, sign fix-up and add to the start
    // point. Every beat passes through, non-crossing ones get zero coordinates.
    sis_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_ready (q_ready),
        .o_res       (o_res)
    );
endmodule

// ----- dv/testbench.sv -----
// Testbench for the 2D segment intersection unit: directed and random pairs, checked per beat.
`timescale 1ns / 1ps
module testbench;
    import sis_pkg::*;

    typedef struct {
        logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    } t_seg_pair;

    typedef struct {
        logic [2:0]           rel;
        logic signed [CW-1:0] px, py;
    } t_isect;

    logic i_clk;
    logic i_rst_n;

    sis_pair_if pair_ch ();
    sis_res_if  res_ch ();

    segment_intersection_2d_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair_ch.sink),
        .o_res   (res_ch.source)
    );

    t_seg_pair pending_pairs[$];
    t_isect    expected_isects[$];
    int        n_mismatch;
    int        n_beats_out;
    int        n_cross;
    bit        stim_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Exact classification in 200-bit signed arithmetic; products never overflow.
    function automatic t_isect classify(t_seg_pair p);
        logic signed [199:0] ax, ay, bx, by, cx, cy, dx, dy;
        logic signed [199:0] dfx, dfy, dsx, dsy, den, side, sp, tp, dn2, zero;
        logic signed [199:0] qx, qy;
        t_isect r;
        ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
        cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
        zero = '0;
        dfx = bx - ax; dfy = by - ay;
        dsx = dx - cx; dsy = dy - cy;
        den = dfy * dsx - dfx * dsy;
        r.rel = REL_PARALLEL;
        r.px = '0;
        r.py = '0;
        if (den == 0) begin
            side = dfx * (cy - ay) - (cx - ax) * dfy;
            r.rel = (side == 0) ? REL_COLLINEAR : REL_PARALLEL;
        end else begin
            sp = -(dfy * (cx - ax) - dfx * (cy - ay));
            if (den < 0 ? !(den <= sp && sp <= zero) : !(zero <= sp && sp <= den)) begin
                r.rel = REL_MISS_SECOND;
            end else begin
                dn2 = -den;
                tp = -(dsy * (ax - cx) - dsx * (ay - cy));
                if (dn2 < 0 ? (dn2 <= tp && tp <= zero) : (zero <= tp && tp <= dn2)) begin
                    r.rel = REL_CROSS;
                    // SV signed division truncates toward zero
                    qx = (dfx * tp) / dn2;
                    qy = (dfy * tp) / dn2;
                    r.px = CW'(ax + qx);
                    r.py = CW'(ay + qy);
                end else begin
                    r.rel = REL_MISS_FIRST;
                end
            end
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        logic signed [CW-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 64)) - 32;
            2: v = CW'($signed($urandom_range(0, 20)) - 10) <<< 16;
            3: v = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
            default: v = $signed($urandom_range(0, 2000000)) - 1000000;
        endcase
        return v;
    endfunction

    task automatic add_pair(input logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy);
        t_seg_pair p;
        p.ax = ax; p.ay = ay; p.bx = bx; p.by = by;
        p.cx = cx; p.cy = cy; p.dx = dx; p.dy = dy;
        pending_pairs = {pending_pairs, p};
    endtask

    // Random pair, half of them shaped to cross or touch so the point path is busy.
    task automatic add_random_pair();
        logic signed [CW-1:0] c[8];
        logic signed [CW-1:0] mx, my;
        int k;
        for (k = 0; k < 8; k++) c[k] = rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                // segments around a shared center: crossing likely
                mx = $signed($urandom_range(0, 2000000)) - 1000000;
                my = $signed($urandom_range(0, 2000000)) - 1000000;
                c[0] = mx - ($signed($urandom_range(0, 65536)));
                c[1] = my - ($signed($urandom_range(0, 65536)) - 32768);
                c[2] = 2 * mx - c[0];
                c[3] = 2 * my - c[1];
                c[4] = mx + ($signed($urandom_range(0, 65536)) - 32768);
                c[5] = my - ($signed($urandom_range(0, 65536)));
                c[6] = 2 * mx - c[4];
                c[7] = 2 * my - c[5];
            end
            4: begin
                // collinear or parallel: second is first shifted
                mx = ($urandom_range(0, 1) != 0) ? 0 : $signed($urandom_range(0, 100)) - 50;
                c[4] = c[0] + mx + (c[2] - c[0]) * 2;
                c[5] = c[1] + (c[3] - c[1]) * 2;
                c[6] = c[4] + (c[2] - c[0]);
                c[7] = c[5] + (c[3] - c[1]);
            end
            5: begin
                // touching at the second segment start
                c[4] = c[($urandom_range(0, 1) != 0) ? 0 : 2];
                c[5] = c[4] == c[0] ? c[1] : c[3];
            end
            6: begin
                // degenerate segment
                if ($urandom_range(0, 1) != 0) begin
                    c[2] = c[0]; c[3] = c[1];
                end else begin
                    c[6] = c[4]; c[7] = c[5];
                end
            end
            default: ;
        endcase
        add_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endtask

    initial begin
        int k;
        localparam logic signed [CW-1:0] MAXC = 32'sh7fffffff;
        localparam logic signed [CW-1:0] MINC = 32'sh80000000;
        localparam logic signed [CW-1:0] ONE  = 32'sh00010000;
        stim_done = 1'b0;
        // proper cross at the origin
        add_pair(-ONE, 0, ONE, 0, 0, -ONE, 0, ONE);
        // full-range diagonals crossing
        add_pair(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
        add_pair(MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC);
        // parallel and collinear
        add_pair(0, 0, ONE, 0, 0, ONE, ONE, ONE);
        add_pair(0, 0, ONE, 0, 2 * ONE, 0, 3 * ONE, 0);
        add_pair(MINC, 0, MAXC, 0, 0, 0, MAXC, 0);
        // lines cross outside the second segment, then outside the first
        add_pair(-ONE, 0, ONE, 0, 0, ONE, 0, 2 * ONE);
        add_pair(0, 0, ONE, 0, 2 * ONE, -ONE, 2 * ONE, ONE);
        // touching at ends
        add_pair(0, 0, ONE, 0, ONE, 0, ONE, ONE);
        add_pair(0, 0, ONE, ONE, 0, 0, -ONE, ONE);
        add_pair(0, 0, 2 * ONE, 0, ONE, 0, ONE, -ONE);
        // degenerate first segment, degenerate second on and off the line
        add_pair(5, 5, 5, 5, 0, 0, ONE, ONE);
        add_pair(0, 0, ONE, ONE, 7, 7, 7, 7);
        add_pair(0, 0, ONE, ONE, 7, 8, 7, 8);
        // inexact quotient, negative direction for truncation
        add_pair(0, 0, -7, -3, -1, -2, -5, 0);
        add_pair(3, 0, -4, 1, 0, -5, 1, 9);
        add_pair(MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC);
        add_pair(-1, -1, -1, -1, -1, -1, -1, -1);
        add_pair(MINC, MAXC, MAXC, MAXC, 0, MINC, 1, MAXC);
        for (k = 0; k < 1530; k++) add_random_pair();
        stim_done = 1'b1;
    end

    // Driver: bursts of beats with random gaps between them.
    int burst_left;
    int gap_left;
    t_seg_pair cur;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pair_ch.valid <= 1'b0;
            burst_left <= $urandom_range(1, 40);
            gap_left <= 0;
        end else begin
            if (pair_ch.valid && pair_ch.ready) begin
                expected_isects = {expected_isects, classify(cur)};
            end
            if (!pair_ch.valid || pair_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    pair_ch.valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    cur = pending_pairs.pop_front();
                    pair_ch.valid <= 1'b1;
                    pair_ch.first_start_x <= cur.ax;
                    pair_ch.first_start_y <= cur.ay;
                    pair_ch.first_end_x <= cur.bx;
                    pair_ch.first_end_y <= cur.by;
                    pair_ch.second_start_x <= cur.cx;
                    pair_ch.second_start_y <= cur.cy;
                    pair_ch.second_end_x <= cur.dx;
                    pair_ch.second_end_y <= cur.dy;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    pair_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Sink stall pattern: phases of always-ready alternate with random stalls.
    int stall_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[8]) res_ch.ready <= 1'b1;
            else res_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_isect e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_beats_out <= n_beats_out + 1;
            if (expected_isects.size() == 0) begin
                n_mismatch <= n_mismatch + 1;
                if (n_mismatch < 10) $display("unexpected result beat rel=%0d", res_ch.relation);
            end else begin
                e = expected_isects.pop_front();
                if (e.rel == REL_CROSS) n_cross <= n_cross + 1;
                if (res_ch.relation !== e.rel || res_ch.cross_x !== e.px
                    || res_ch.cross_y !== e.py) begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("mismatch: exp rel=%0d x=%0d y=%0d, got rel=%0d x=%0d y=%0d",
                                 e.rel, e.px, e.py, res_ch.relation,
                                 res_ch.cross_x, res_ch.cross_y);
                end
            end
        end
    end

    initial begin
        int k;
        n_mismatch = 0;
        n_beats_out = 0;
        n_cross = 0;
        pair_ch.valid = 1'b0;
        pair_ch.first_start_x = '0;
        pair_ch.first_start_y = '0;
        pair_ch.first_end_x = '0;
        pair_ch.first_end_y = '0;
        pair_ch.second_start_x = '0;
        pair_ch.second_start_y = '0;
        pair_ch.second_end_x = '0;
        pair_ch.second_end_y = '0;
        res_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        // sample at the falling edge, away from the driver and monitor updates
        @(negedge i_clk);
        while (pending_pairs.size() > 0 || pair_ch.valid || expected_isects.size() > 0)
            @(negedge i_clk);
        // drain: let any stray beat show up after the pipeline latency
        repeat (100) @(posedge i_clk);
        $display("covered %0d segment pairs, %0d true crossings, under bursty input and stalls",
                 n_beats_out, n_cross);
        if (n_mismatch == 0) begin
            $display("segment_intersection_2d_unit regression: pass");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("segment_intersection_2d_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("segment_intersection_2d_unit regression: fail");
        $finish;
    end
endmodule
